// ----- sv/rof3_pkg.sv -----
// types, constants and the rank selector shared by the 3x3 rank-order filter
package rof3_pkg;

    localparam int PIX_W   = 16;
    localparam int RANK_W  = 4;
    localparam int WIDTH_W = 12;
    localparam int ROW_W   = 13;
    localparam int CFG_W   = 13;
    localparam int WIN_N   = 9;

    typedef logic [PIX_W-1:0]             pix_t;
    typedef logic [2:0][PIX_W-1:0]        row_t;
    typedef logic [2:0][2:0][PIX_W-1:0]   win_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0]  cand_t;

    typedef enum logic [1:0] {
        REG_RANK   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    // bit 0 mirrors the bottom row, bit 1 mirrors the right column
    typedef enum logic [1:0] {
        STEP_MAIN   = 2'b00,
        STEP_BOTTOM = 2'b01,
        STEP_RIGHT  = 2'b10,
        STEP_CORNER = 2'b11
    } step_t;

    function automatic row_t col_pick(input row_t x, input logic mirror, input logic left_m);
        row_t y;
        y[0] = mirror ? x[1] : (left_m ? x[2] : x[0]);
        y[1] = mirror ? x[2] : x[1];
        y[2] = mirror ? x[1] : x[2];
        return y;
    endfunction

    // k is zero based; ties ordered by position
    function automatic pix_t rank_pick(input cand_t v, input logic [RANK_W-1:0] k);
        logic [RANK_W-1:0] pos;
        pix_t              res;
        res = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            pos = '0;
            for (int j = 0; j < WIN_N; j++)
            begin
                if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i)))
                    pos = pos + RANK_W'(1);
            end
            if (pos == k)
                res = v[i];
        end
        return res;
    endfunction

endpackage

// ----- sv/rank_order_filter_3x3.sv -----
// top level of the 3x3 rank-order filter: line memory, window and result sequencer
//
// Streams an image in raster order and returns, for each pixel, the rank-th smallest
// value of its 3x3 neighbourhood (rank 1 erosion, 5 median, 9 dilation), with
// border neighbours mirrored about the edge pixel. Results trail the input by one
// row and one pixel. A pixel is taken every cycle unless pending results or output
// back-pressure hold the input; the two rows above are kept in one single-port-read,
// single-port-write memory of MAX_WIDTH words holding both rows side by side, read
// when a pixel is taken and written back when that pixel moves into the window.
// Each result leaves through a single rank selector, one per cycle unless the output
// stalls, so a pixel on the last column or last row holds the input while each extra
// result leaves (up to three for the bottom-right pixel). Output is registered; tlast
// marks the final result caused by an input pixel and tuser the bottom-right result.
// The user must write rank, image_width, image_height only while idle; the block does not enforce it.
module rank_order_filter_3x3
    import rof3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIX_W-1:0]   s_axis_tdata,   // pixel_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [PIX_W-1:0]   m_axis_tdata,   // pixel_out
    output logic               m_axis_tlast,   // last_in_run
    output logic               m_axis_tuser    // frame_done
);

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW    = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

    logic [RANK_W-1:0]  rank_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] mem_rd_reg;

    logic               s1_valid_reg;
    pix_t               s1_pix_reg;
    logic [COL_W-1:0]   s1_idx_reg;
    logic               s1_out_reg;
    logic               s1_top_reg;
    logic               s1_left_reg;
    logic               s1_lc_reg;
    logic               s1_lr_reg;

    win_t               win_reg;

    logic               e_valid_reg;
    step_t              e_step_reg;
    step_t              e_step_next;
    logic               e_top_reg;
    logic               e_left_reg;
    logic               e_lc_reg;
    logic               e_lr_reg;
    logic               e_last;

    logic               out_valid_reg;
    pix_t               out_pix_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic [LW-1:0]      w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic               last_c;
    logic               last_r;
    logic               accept;
    logic               out_load;
    logic               e_finish;
    logic               s1_adv;
    logic [RANK_W-1:0]  k_sel;
    row_t               ra;
    row_t               rb;
    row_t               rc;
    cand_t              cand;
    pix_t               upper_rd;
    pix_t               lower_rd;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg   <= RANK_W'(5);
            width_reg  <= WIDTH_W'(2048);
            height_reg <= ROW_W'(2048);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_RANK:   rank_reg   <= cfg_data[RANK_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = LW'(width_reg);
        if (w_eff < LW'(2))
            w_eff = LW'(2);
        if (w_eff > LW'(MAX_WIDTH))
            w_eff = LW'(MAX_WIDTH);
        h_eff = (height_reg < ROW_W'(2)) ? ROW_W'(2) : height_reg;
        if (rank_reg == '0)
            k_sel = '0;
        else if (rank_reg > RANK_W'(9))
            k_sel = RANK_W'(8);
        else
            k_sel = rank_reg - RANK_W'(1);
    end

    assign last_c = (LW'(col_reg) >= (w_eff - LW'(1)));
    assign last_r = (row_reg >= (h_eff - ROW_W'(1)));

    // handshake and stage control
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign e_finish      = e_valid_reg && out_load && e_last;
    assign s1_adv        = s1_valid_reg && (!e_valid_reg || e_finish);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_c)
            begin
                col_reg <= '0;
                row_reg <= last_r ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // line memory: upper row in the high half, lower row in the low half
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            mem[s1_idx_reg] <= {lower_rd, s1_pix_reg};
        if (accept)
            mem_rd_reg <= mem[col_reg];
    end

    assign upper_rd = mem_rd_reg[2*PIX_W-1:PIX_W];
    assign lower_rd = mem_rd_reg[PIX_W-1:0];

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= s_axis_tdata;
            s1_idx_reg  <= col_reg;
            s1_out_reg  <= (row_reg != '0) && (col_reg != '0);
            s1_top_reg  <= (row_reg == ROW_W'(1));
            s1_left_reg <= (col_reg == COL_W'(1));
            s1_lc_reg   <= last_c;
            s1_lr_reg   <= last_r;
        end
    end

    // window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= upper_rd;
            win_reg[1][2] <= lower_rd;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // result sequencer
    always_comb
    begin
        e_step_next = STEP_MAIN;
        e_last      = 1'b1;
        case (e_step_reg)
            STEP_MAIN:
            begin
                if (e_lr_reg)
                begin
                    e_step_next = STEP_BOTTOM;
                    e_last      = 1'b0;
                end
                else if (e_lc_reg)
                begin
                    e_step_next = STEP_RIGHT;
                    e_last      = 1'b0;
                end
            end
            STEP_BOTTOM:
            begin
                if (e_lc_reg)
                begin
                    e_step_next = STEP_RIGHT;
                    e_last      = 1'b0;
                end
            end
            STEP_RIGHT:
            begin
                if (e_lr_reg)
                begin
                    e_step_next = STEP_CORNER;
                    e_last      = 1'b0;
                end
            end
            STEP_CORNER: e_last = 1'b1;
            default:     e_last = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            e_step_reg  <= STEP_MAIN;
        end
        else if (s1_adv)
        begin
            e_valid_reg <= s1_out_reg;
            e_step_reg  <= STEP_MAIN;
        end
        else if (e_finish)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (e_valid_reg && out_load)
        begin
            e_step_reg <= e_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            e_top_reg  <= s1_top_reg;
            e_left_reg <= s1_left_reg;
            e_lc_reg   <= s1_lc_reg;
            e_lr_reg   <= s1_lr_reg;
        end
    end

    // mirrored window for the current result
    always_comb
    begin
        if (e_step_reg[0])
        begin
            ra = win_reg[1];
            rb = win_reg[2];
            rc = win_reg[1];
        end
        else
        begin
            ra = e_top_reg ? win_reg[2] : win_reg[0];
            rb = win_reg[1];
            rc = win_reg[2];
        end
        cand = {col_pick(rc, e_step_reg[1], e_left_reg),
                col_pick(rb, e_step_reg[1], e_left_reg),
                col_pick(ra, e_step_reg[1], e_left_reg)};
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= e_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && e_valid_reg)
        begin
            out_pix_reg  <= rank_pick(cand, k_sel);
            out_last_reg <= e_last;
            out_done_reg <= (e_step_reg == STEP_CORNER);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

    // checks
    a_frame_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame done without last transfer");

    a_mem_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && accept) |-> (s1_idx_reg != col_reg))
        else $error("line memory read and write hit the same column");

    a_corner_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && (e_step_reg == STEP_CORNER)) |-> (e_lc_reg && e_lr_reg))
        else $error("corner result outside the last row and column");

    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !e_finish) |=> (win_reg === $past(win_reg)))
        else $error("window moved while results were pending");

endmodule

// ----- sim/rank_filter_checker.sv -----
// checker for the 3x3 rank-order filter: predicts every ranked pixel and compares it with the output
`timescale 1ns / 100ps

module rank_filter_checker
    import rof3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [PIX_W-1:0] s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [PIX_W-1:0] m_axis_tdata,
    input  logic             m_axis_tlast,
    input  logic             m_axis_tuser,
    output int               mismatches,
    output int               pending
);

    localparam int LINE_MAX = 2048;

    typedef struct packed {
        pix_t value;
        logic last;
        logic done;
    } ranked_t;

    ranked_t           ranked_q[$];
    pix_t              upper_row[LINE_MAX];
    pix_t              lower_row[LINE_MAX];
    pix_t              win[WIN_N];
    logic [10:0]       col_cnt;
    logic [12:0]       row_cnt;
    logic [RANK_W-1:0] cfg_rank;
    logic [WIDTH_W-1:0] cfg_width;
    logic [ROW_W-1:0]  cfg_height;
    int                result_no;

    initial
    begin
        for (int i = 0; i < LINE_MAX; i++)
        begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        for (int i = 0; i < WIN_N; i++)
            win[i] = '0;
        col_cnt    = '0;
        row_cnt    = '0;
        cfg_rank   = 4'd5;
        cfg_width  = 12'd2048;
        cfg_height = 13'd2048;
        mismatches = 0;
        pending    = 0;
        result_no  = 0;
    end

    // window rows: 0 two rows above, 2 current row; columns: 0 oldest, 2 newest
    function automatic pix_t pick_ranked(input int rt, input int rm, input int rb,
                                         input int cl, input int cm, input int cr);
        int   rows[3];
        int   cols[3];
        pix_t v[WIN_N];
        pix_t x;
        int   j;
        int   k;
        rows = '{rt, rm, rb};
        cols = '{cl, cm, cr};
        for (int i = 0; i < 3; i++)
            for (int jj = 0; jj < 3; jj++)
                v[i*3+jj] = win[rows[i]*3 + cols[jj]];
        for (int i = 1; i < WIN_N; i++)
        begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x)
            begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        if (cfg_rank == 0)
            k = 0;
        else if (cfg_rank > 9)
            k = 8;
        else
            k = int'(cfg_rank) - 1;
        return v[k];
    endfunction

    task automatic filter_pixel(input pix_t pix);
        int      w;
        int      h;
        int      c;
        int      r;
        int      idx;
        int      top;
        int      left;
        int      n;
        bit      last_c;
        bit      last_r;
        pix_t    vals[4];
        bit      dones[4];
        ranked_t item;
        w = int'(cfg_width);
        h = int'(cfg_height);
        if (w < 2)
            w = 2;
        if (w > LINE_MAX)
            w = LINE_MAX;
        if (h < 2)
            h = 2;
        c = int'(col_cnt);
        r = int'(row_cnt);
        idx = (c < LINE_MAX) ? c : LINE_MAX - 1;
        for (int i = 0; i < 3; i++)
        begin
            win[i*3+0] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = upper_row[idx];
        win[5] = lower_row[idx];
        win[8] = pix;
        upper_row[idx] = lower_row[idx];
        lower_row[idx] = pix;
        last_c = (c >= w - 1);
        last_r = (r >= h - 1);
        n = 0;
        if (r >= 1 && c >= 1)
        begin
            top  = (r == 1) ? 2 : 0;
            left = (c == 1) ? 2 : 0;
            vals[n] = pick_ranked(top, 1, 2, left, 1, 2);
            dones[n] = 1'b0;
            n++;
            if (last_r)
            begin
                vals[n] = pick_ranked(1, 2, 1, left, 1, 2);
                dones[n] = 1'b0;
                n++;
            end
            if (last_c)
            begin
                vals[n] = pick_ranked(top, 1, 2, 1, 2, 1);
                dones[n] = 1'b0;
                n++;
                if (last_r)
                begin
                    vals[n] = pick_ranked(1, 2, 1, 1, 2, 1);
                    dones[n] = 1'b1;
                    n++;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                item.value = vals[i];
                item.last  = (i == n - 1);
                item.done  = dones[i];
                ranked_q.push_back(item);
            end
        end
        if (last_c)
        begin
            col_cnt = '0;
            row_cnt = last_r ? 13'd0 : row_cnt + 13'd1;
        end
        else
            col_cnt = col_cnt + 11'd1;
    endtask

    always @(posedge clk)
    begin
        ranked_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (ranked_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("result %0d: none expected, got %h last %b frame %b",
                                 result_no, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = ranked_q.pop_front();
                    if (m_axis_tdata !== want.value || m_axis_tlast !== want.last ||
                        m_axis_tuser !== want.done)
                    begin
                        if (mismatches < 10)
                            $display("result %0d: expected %h last %b frame %b, got %h last %b frame %b",
                                     result_no, want.value, want.last, want.done,
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
                        mismatches++;
                    end
                end
                result_no++;
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_RANK:   cfg_rank   = cfg_data[RANK_W-1:0];
                    REG_WIDTH:  cfg_width  = cfg_data[WIDTH_W-1:0];
                    REG_HEIGHT: cfg_height = cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                filter_pixel(s_axis_tdata);
            pending <= ranked_q.size();
        end
    end

endmodule

// ----- sim/rank_order_filter_3x3_test.sv -----
// testbench top for the 3x3 rank-order filter: clock, reset, frame stimulus and verdict
`timescale 1ns / 100ps

module rank_order_filter_3x3_test;
    import rof3_pkg::*;

    typedef enum int {
        PIX_PLANNED,
        PIX_RANDOM,
        PIX_LEVELS,
        PIX_TIES
    } pix_style_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_we        = 1'b0;
    logic [1:0]       cfg_addr      = REG_RANK;
    logic [CFG_W-1:0] cfg_data      = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [PIX_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;
    logic             m_axis_tuser;

    int   mismatches;
    int   pending;
    int   pixels_sent = 0;
    bit   in_steady   = 1'b0;
    bit   out_steady  = 1'b0;
    pix_t pix_plan[$];

    always #4 clk = ~clk;

    rank_order_filter_3x3 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    rank_filter_checker rank_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // output side: random stall before each transfer unless the frame runs steady
    initial
    begin
        int stall;
        forever
        begin
            stall = out_steady ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial
    begin
        #40_000_000;
        $display("rank_order_filter_3x3: mismatch");
        $finish;
    end

    function automatic pix_t make_pixel(input pix_style_t style);
        case (style)
            PIX_PLANNED: return pix_plan.pop_front();
            PIX_LEVELS:  return pix_t'(16'h5555 * $urandom_range(0, 3));
            PIX_TIES:    return pix_t'($urandom_range(0, 7));
            default:
            begin
                if ($urandom_range(0, 7) == 0)
                    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                return pix_t'($urandom());
            end
        endcase
    endfunction

    task automatic send_pixel(input pix_t pix);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        pixels_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_W-1:0] rk, input logic [CFG_W-1:0] wd,
                             input logic [CFG_W-1:0] ht);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_RANK;
        cfg_data <= rk;
        @(posedge clk);
        cfg_addr <= REG_WIDTH;
        cfg_data <= wd;
        @(posedge clk);
        cfg_addr <= REG_HEIGHT;
        cfg_data <= ht;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_frame(input logic [CFG_W-1:0] rk, input logic [CFG_W-1:0] wd,
                             input logic [CFG_W-1:0] ht, input pix_style_t style,
                             input bit steady);
        int ew;
        int eh;
        settle();
        write_cfg(rk, wd, ht);
        ew = (wd < 2) ? 2 : ((wd > 2048) ? 2048 : int'(wd));
        eh = (ht < 2) ? 2 : int'(ht);
        in_steady  = steady;
        out_steady = steady;
        for (int i = 0; i < ew * eh; i++)
            send_pixel(make_pixel(style));
    endtask

    initial
    begin
        logic [CFG_W-1:0] rk;
        logic [CFG_W-1:0] wd;
        logic [CFG_W-1:0] ht;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rank, width and height below range, extreme pixels
        pix_plan = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
        run_frame(0, 1, 0, PIX_PLANNED, 1'b0);
        // rank above range on a 3x3 image
        pix_plan = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF,
                     16'hFFFE, 16'h0000, 16'hFFFF, 16'h0002};
        run_frame(15, 3, 3, PIX_PLANNED, 1'b0);
        // median with ties
        pix_plan = '{16'h0005, 16'h0005, 16'h0005, 16'h0000, 16'hFFFF, 16'h0005};
        run_frame(5, 2, 3, PIX_PLANNED, 1'b1);

        while (pixels_sent < 230)
        begin
            rk = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 15))
                                             : CFG_W'($urandom_range(1, 9));
            case ($urandom_range(0, 9))
                0:       wd = CFG_W'($urandom_range(0, 1));
                1:       wd = CFG_W'($urandom_range(10, 16));
                default: wd = CFG_W'($urandom_range(2, 9));
            endcase
            ht = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 1))
                                             : CFG_W'($urandom_range(2, 6));
            run_frame(rk, wd, ht, pix_style_t'($urandom_range(1, 3)),
                      $urandom_range(0, 3) == 0);
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("rank_order_filter_3x3: match");
        else
            $display("rank_order_filter_3x3: mismatch");
        $finish;
    end

endmodule

// ----- rank_order_filter_3x3.f -----
sv/rof3_pkg.sv
sv/rank_order_filter_3x3.sv
sim/rank_filter_checker.sv
sim/rank_order_filter_3x3_test.sv
